@@ rtl/core/hsp_pkg.sv @@
// shared types and constants of the half-step positioner
package hsp_pkg;

    localparam int POS_FIELD_W = 17;
    localparam int TOL_FIELD_W = 10;
    localparam int RING_SIZE   = 8;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;

    localparam logic [1:0] CLASS_OPEN    = 2'd0;
    localparam logic [1:0] CLASS_HALF    = 2'd1;
    localparam logic [1:0] CLASS_CLOSED  = 2'd2;
    localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

    localparam logic [1:0] REG_OPEN_POSITION   = 2'd0;
    localparam logic [1:0] REG_HALF_POSITION   = 2'd1;
    localparam logic [1:0] REG_CLOSED_POSITION = 2'd2;
    localparam logic [1:0] REG_CLASS_TOLERANCE = 2'd3;

    localparam logic [POS_FIELD_W-1:0] OPEN_RESET   = 17'd0;
    localparam logic [POS_FIELD_W-1:0] HALF_RESET   = 17'd40000;
    localparam logic [POS_FIELD_W-1:0] CLOSED_RESET = 17'd86000;
    localparam logic [TOL_FIELD_W-1:0] TOL_RESET    = 10'd10;

    // half-step ring A, AB, B, BC, C, CD, D, DA
    localparam logic [3:0] RING_PATTERN [RING_SIZE] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    typedef struct packed {
        logic [1:0]             op;
        logic [POS_FIELD_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [3:0]             coils;
        logic [POS_FIELD_W-1:0] position;
        logic                   running;
        logic                   arrived;
        logic [1:0]             position_class;
    } out_word_t;

    typedef struct packed {
        logic [POS_FIELD_W-1:0] open_position;
        logic [POS_FIELD_W-1:0] half_position;
        logic [POS_FIELD_W-1:0] closed_position;
        logic [TOL_FIELD_W-1:0] class_tolerance;
    } cfg_t;

endpackage

@@ rtl/core/hsp_motion.sv @@
// position, target and phase state with its per-word next-state logic
module hsp_motion #(
    parameter int POSITION_BITS = 17,
    parameter int PHASE_COUNT   = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_en,
    input  logic [1:0]               op,
    input  logic [POSITION_BITS-1:0] value,
    output logic [POSITION_BITS-1:0] pos_next,
    output logic                     moving_next,
    output logic                     arrived,
    output logic [3:0]               coil_next
);
    import hsp_pkg::*;

    localparam int PB = $clog2(PHASE_COUNT);

    typedef logic [3:0] phase_coils_t [PHASE_COUNT];

    // phase p drives ring entry p * 8 / PHASE_COUNT
    function automatic phase_coils_t build_phase_coils();
        phase_coils_t tab;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            tab[PB'(p)] = RING_PATTERN[3'((p * RING_SIZE) / PHASE_COUNT)];
        end
        return tab;
    endfunction

    localparam phase_coils_t PHASE_COILS = build_phase_coils();

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic [PB-1:0]            phase_reg, phase_next;
    logic                     moving_reg;
    logic [3:0]               coil_reg;

    always_comb begin
        pos_next    = pos_reg;
        target_next = target_reg;
        phase_next  = phase_reg;
        moving_next = moving_reg;
        coil_next   = coil_reg;
        arrived     = 1'b0;
        unique case (op)
            OP_TICK: begin
                if (moving_reg) begin
                    if (pos_reg == target_reg) begin
                        moving_next = 1'b0;
                        coil_next   = 4'h0;
                        arrived     = 1'b1;
                    end else begin
                        if (pos_reg < target_reg) begin
                            if (({1'b0, phase_reg} + 1'b1) >= (PB+1)'(PHASE_COUNT)) begin
                                phase_next = '0;
                            end else begin
                                phase_next = phase_reg + 1'b1;
                            end
                            pos_next = pos_reg + 1'b1;
                        end else begin
                            if (phase_reg == '0) begin
                                phase_next = PB'(PHASE_COUNT - 1);
                            end else begin
                                phase_next = phase_reg - 1'b1;
                            end
                            pos_next = pos_reg - 1'b1;
                        end
                        coil_next = PHASE_COILS[phase_next];
                    end
                end
            end
            OP_MOVE: begin
                target_next = value;
                moving_next = 1'b1;
            end
            OP_SET: begin
                pos_next    = value;
                target_next = value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            target_reg <= '0;
            phase_reg  <= '0;
            moving_reg <= 1'b0;
            coil_reg   <= 4'h0;
        end else if (step_en) begin
            pos_reg    <= pos_next;
            target_reg <= target_next;
            phase_reg  <= phase_next;
            moving_reg <= moving_next;
            coil_reg   <= coil_next;
        end
    end

endmodule

@@ rtl/core/hsp_classify.sv @@
// position class against the open, half and closed presets
module hsp_classify #(
    parameter int CW = 18
) (
    input  hsp_pkg::cfg_t cfg,
    input  logic [CW-1:0] pos,
    output logic [1:0]    position_class
);
    import hsp_pkg::*;

    logic [CW-1:0] open_lim;
    logic [CW-1:0] half_w;
    logic [CW-1:0] tol_w;
    logic [CW-1:0] half_dist;
    logic [CW-1:0] pos_plus_tol;

    always_comb begin
        tol_w        = CW'(cfg.class_tolerance);
        half_w       = CW'(cfg.half_position);
        open_lim     = CW'(cfg.open_position) + tol_w;
        half_dist    = (pos >= half_w) ? (pos - half_w) : (half_w - pos);
        pos_plus_tol = pos + tol_w;
        priority if (pos < open_lim) begin
            position_class = CLASS_OPEN;
        end else if (half_dist < tol_w) begin
            position_class = CLASS_HALF;
        end else if (pos_plus_tol > CW'(cfg.closed_position)) begin
            position_class = CLASS_CLOSED;
        end else begin
            position_class = CLASS_UNKNOWN;
        end
    end

endmodule

@@ rtl/core/stepper_half_step_positioner_core.sv @@
// top level: input register, motion state, classifier, result register
//
// Half-step positioner for a four-coil stepper. One word is taken per clock
// cycle unless back-pressure holds it; its result passes from the input
// register into the result register, and the position counter, phase step
// and preset comparisons are combinational between the input and result
// registers. Back-pressure on m_ready stalls the input register, and s_ready
// stays high while the result register can drain. Configuration writes on
// cfg_we are registered into the presets and are meant to happen while no
// word is in flight. coils is zero whenever running is low.
module stepper_half_step_positioner_core #(
    parameter int POSITION_BITS = 17,
    parameter int PHASE_COUNT   = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hsp_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hsp_pkg::out_word_t m_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_wdata
);
    import hsp_pkg::*;

    localparam int CW = ((POSITION_BITS > POS_FIELD_W) ? POSITION_BITS : POS_FIELD_W) + 1;

    cfg_t      cfg_reg, cfg_next;
    logic      in_valid_reg, in_valid_next;
    in_word_t  in_data_reg, in_data_next;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg, out_data_next;
    logic      advance;

    logic [POSITION_BITS-1:0] pos_next;
    logic                     moving_next;
    logic                     arrived;
    logic [3:0]               coil_next;
    logic [1:0]               pos_class;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    hsp_motion #(
        .POSITION_BITS(POSITION_BITS),
        .PHASE_COUNT  (PHASE_COUNT)
    ) u_motion (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .op         (in_data_reg.op),
        .value      (POSITION_BITS'(in_data_reg.value)),
        .pos_next   (pos_next),
        .moving_next(moving_next),
        .arrived    (arrived),
        .coil_next  (coil_next)
    );

    hsp_classify #(
        .CW(CW)
    ) u_classify (
        .cfg           (cfg_reg),
        .pos           (CW'(pos_next)),
        .position_class(pos_class)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_OPEN_POSITION:   cfg_next.open_position   = cfg_wdata;
                REG_HALF_POSITION:   cfg_next.half_position   = cfg_wdata;
                REG_CLOSED_POSITION: cfg_next.closed_position = cfg_wdata;
                REG_CLASS_TOLERANCE: cfg_next.class_tolerance = cfg_wdata[TOL_FIELD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next               = 1'b1;
            out_data_next.coils          = coil_next;
            out_data_next.position       = POS_FIELD_W'(pos_next);
            out_data_next.running        = moving_next;
            out_data_next.arrived        = arrived;
            out_data_next.position_class = pos_class;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_position   <= OPEN_RESET;
            cfg_reg.half_position   <= HALF_RESET;
            cfg_reg.closed_position <= CLOSED_RESET;
            cfg_reg.class_tolerance <= TOL_RESET;
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    // coils are released whenever the motor is stopped
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.running || m_data.coils == 4'h0))
        else $error("coils driven while stopped");

    // arrival always ends the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.arrived) |-> !m_data.running)
        else $error("arrived while still running");

    // a half-step pattern energizes one or two coils
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.running && m_data.coils != 4'h0) |->
            ($countones(m_data.coils) == 1 || $countones(m_data.coils) == 2))
        else $error("illegal coil pattern");

    // a held word in the input register is not dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word lost while stalled");

endmodule

@@ dv/tb_stepper_half_step_positioner_core.sv @@
// testbench of the half-step positioner: random and directed words checked against a local model
`timescale 1ns / 100ps

module tb_stepper_half_step_positioner_core;
    import hsp_pkg::*;

    localparam int MAX_STEP   = (1 << POS_FIELD_W) - 1;
    localparam int MAX_TOL    = (1 << TOL_FIELD_W) - 1;
    localparam int PHASES     = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [3:0] HALF_STEP_COILS [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_word_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_word_t  m_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_OPEN_POSITION;
    logic [16:0] cfg_wdata = '0;

    stepper_half_step_positioner_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    in_word_t  pending_words [$];
    out_word_t expected_words [$];
    int        mismatch_count = 0;

    // presets and positioner state as the block should hold them
    int cfg_open = int'(OPEN_RESET);
    int cfg_half = int'(HALF_RESET);
    int cfg_closed = int'(CLOSED_RESET);
    int cfg_tol = int'(TOL_RESET);

    logic [POS_FIELD_W-1:0] pm_pos = '0;
    logic [POS_FIELD_W-1:0] pm_target = '0;
    int                     pm_phase = 0;
    logic                   pm_moving = 1'b0;
    logic [3:0]             pm_coils = '0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [1:0] classify_position(logic [POS_FIELD_W-1:0] p);
        int pos;
        int half_gap;
        pos = int'(p);
        half_gap = (pos >= cfg_half) ? pos - cfg_half : cfg_half - pos;
        if (pos < cfg_open + cfg_tol)
            return CLASS_OPEN;
        if (half_gap < cfg_tol)
            return CLASS_HALF;
        if (pos + cfg_tol > cfg_closed)
            return CLASS_CLOSED;
        return CLASS_UNKNOWN;
    endfunction

    function automatic out_word_t advance_positioner(in_word_t w);
        out_word_t r;
        logic hit;
        hit = 1'b0;
        case (w.op)
            OP_TICK: begin
                if (pm_moving) begin
                    if (pm_pos == pm_target) begin
                        pm_moving = 1'b0;
                        pm_coils = '0;
                        hit = 1'b1;
                    end else begin
                        if (pm_pos < pm_target) begin
                            pm_phase = (pm_phase + 1) % PHASES;
                            pm_pos = pm_pos + 1'b1;
                        end else begin
                            pm_phase = (pm_phase == 0) ? PHASES - 1 : pm_phase - 1;
                            pm_pos = pm_pos - 1'b1;
                        end
                        pm_coils = HALF_STEP_COILS[(pm_phase * 8) / PHASES];
                    end
                end
            end
            OP_MOVE: begin
                pm_target = w.value;
                pm_moving = 1'b1;
            end
            OP_SET: begin
                pm_pos = w.value;
                pm_target = w.value;
            end
            default: ;
        endcase
        r.coils = pm_coils;
        r.position = pm_pos;
        r.running = pm_moving;
        r.arrived = hit;
        r.position_class = classify_position(pm_pos);
        return r;
    endfunction

    function automatic int draw_wait(logic burst);
        return burst ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // driver
    int   send_hold = 0;
    logic send_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_hold <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_words.push_back(advance_positioner(s_data));
            if (!s_valid || s_ready) begin
                if (send_hold > 0) begin
                    s_valid <= 1'b0;
                    send_hold <= send_hold - 1;
                end else if (pending_words.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_words.pop_front();
                    send_hold <= draw_wait(send_burst);
                    if ($urandom_range(0, 39) == 0)
                        send_burst <= !send_burst;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int   recv_hold = 0;
    logic recv_burst = 1'b0;

    always @(posedge aclk) begin
        out_word_t want;
        int n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: no word expected, actual %p", $time, m_data);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("coils", want.coils, m_data.coils);
                    check_field("position", want.position, m_data.position);
                    check_field("running", want.running, m_data.running);
                    check_field("arrived", want.arrived, m_data.arrived);
                    check_field("position_class", want.position_class,
                                m_data.position_class);
                end
                n = draw_wait(recv_burst);
                if ($urandom_range(0, 39) == 0)
                    recv_burst <= !recv_burst;
                recv_hold <= n;
                m_ready <= (n == 0);
            end else if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                m_ready <= (recv_hold == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("stepper_half_step_positioner_core: mismatch");
                $finish;
            end
        end
    end

    task automatic queue_word(logic [1:0] op, int value);
        in_word_t w;
        w.op = op;
        w.value = value[POS_FIELD_W-1:0];
        pending_words.push_back(w);
    endtask

    function automatic int clamp_step(int v);
        if (v < 0)
            return 0;
        if (v > MAX_STEP)
            return MAX_STEP;
        return v;
    endfunction

    function automatic int pick_anchor();
        int slack;
        int base;
        slack = cfg_tol + 4;
        case ($urandom_range(0, 3))
            0: base = cfg_open;
            1: base = cfg_half;
            2: base = cfg_closed;
            default: return int'($urandom_range(0, MAX_STEP));
        endcase
        return clamp_step(base + int'($urandom_range(0, 2 * slack)) - slack);
    endfunction

    task automatic queue_random_words(int n_words);
        int queued;
        int anchor;
        int span;
        int target;
        int steps;
        queued = 0;
        while (queued < n_words) begin
            if ($urandom_range(0, 9) < 7) begin
                anchor = pick_anchor();
                span = int'($urandom_range(0, 24));
                target = clamp_step($urandom_range(0, 1) ? anchor + span : anchor - span);
                queue_word(OP_SET, anchor);
                queue_word(OP_MOVE, target);
                steps = span + 1 + int'($urandom_range(0, 2));
                queued += 2 + steps;
                repeat (steps) begin
                    case ($urandom_range(0, 29))
                        0: queue_word(OP_MOVE,
                                      clamp_step(target + int'($urandom_range(0, 8)) - 4));
                        1: queue_word(OP_SET,
                                      clamp_step(anchor + int'($urandom_range(0, 8)) - 4));
                        default: queue_word(OP_TICK, int'($urandom_range(0, MAX_STEP)));
                    endcase
                end
            end else begin
                queue_word(2'($urandom_range(0, 3)), int'($urandom_range(0, MAX_STEP)));
                queued++;
            end
        end
    endtask

    task automatic write_register(logic [1:0] idx, int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[16:0];
        case (idx)
            REG_OPEN_POSITION:   cfg_open = value;
            REG_HALF_POSITION:   cfg_half = value;
            REG_CLOSED_POSITION: cfg_closed = value;
            REG_CLASS_TOLERANCE: cfg_tol = value;
            default: ;
        endcase
    endtask

    task automatic apply_presets(int open_p, int half_p, int closed_p, int tol);
        write_register(REG_OPEN_POSITION, open_p);
        write_register(REG_HALF_POSITION, half_p);
        write_register(REG_CLOSED_POSITION, closed_p);
        write_register(REG_CLASS_TOLERANCE, tol);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || expected_words.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // tick and unused op at reset, short move, far end, retarget, recalibrate
        queue_word(OP_TICK, 0);
        queue_word(OP_NONE, 0);
        queue_word(OP_MOVE, 3);
        repeat (4) queue_word(OP_TICK, MAX_STEP);
        queue_word(OP_TICK, 0);
        queue_word(OP_SET, MAX_STEP);
        queue_word(OP_MOVE, MAX_STEP - 2);
        queue_word(OP_TICK, 0);
        queue_word(OP_MOVE, 40005);
        queue_word(OP_TICK, 0);
        queue_word(OP_SET, 40003);
        queue_word(OP_TICK, 0);
        queue_word(OP_MOVE, 40001);
        repeat (3) queue_word(OP_TICK, 0);
        queue_word(OP_SET, 0);
        queue_word(OP_NONE, MAX_STEP);
        queue_word(OP_MOVE, 0);
        queue_word(OP_TICK, 0);
        queue_random_words(100);
        wait_idle();

        apply_presets(0, 0, 0, 0);
        queue_random_words(100);
        wait_idle();

        apply_presets(MAX_STEP, MAX_STEP, MAX_STEP, MAX_TOL);
        queue_random_words(100);
        wait_idle();

        apply_presets($urandom_range(0, 2000), $urandom_range(20000, 60000),
                      $urandom_range(70000, MAX_STEP), $urandom_range(0, MAX_TOL));
        queue_random_words(100);
        wait_idle();

        apply_presets($urandom_range(0, MAX_STEP), $urandom_range(0, MAX_STEP),
                      $urandom_range(0, MAX_STEP), $urandom_range(0, 40));
        queue_random_words(100);
        wait_idle();

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("stepper_half_step_positioner_core: match");
        end else begin
            $display("stepper_half_step_positioner_core: mismatch");
        end
        $finish;
    end

endmodule
